>>> src/gsct_pkg.sv
// ----------------------------------------------------------------------------
// gsct_pkg
// Shared types and constants for the growing sphere contact-time pipeline.
// ----------------------------------------------------------------------------
package gsct_pkg;

  typedef enum logic [1:0] {
    RES_CALC,
    RES_NEVER,
    RES_ZERO,
    RES_OVERLAP
  } res_kind_t;

  localparam int SCALE_SHIFT = 18;
  localparam int TOL_SHIFT   = 10;

  localparam logic [2:0] ADDR_HARD_WALLS = 3'd0;

endpackage

>>> src/gsct_quad.sv
// ----------------------------------------------------------------------------
// gsct_quad
// Two register stages: component products, then the sums A, B and C.
// ----------------------------------------------------------------------------
module gsct_quad
  import gsct_pkg::*;
#(
  parameter int W  = 32,
  parameter int D  = 3,
  parameter int AW = 2 * W + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [W-1:0]  p [3],
  input  logic signed [W-1:0]  v [3],
  input  logic        [W-1:0]  r,
  input  logic        [W-1:0]  g,
  input  logic                 in_never,
  output logic                 out_valid,
  output logic signed [AW-1:0] a,
  output logic signed [AW-1:0] b,
  output logic signed [AW-1:0] c,
  output logic        [W-1:0]  rtol,
  output logic                 out_never
);

  logic signed [2*W-1:0] pp [D];
  logic signed [2*W-1:0] pv [D];
  logic signed [2*W-1:0] vv [D];
  logic        [2*W-1:0] gg, rg, rr;
  logic        [W-1:0]   r1;
  logic                  v1, n1;
  logic signed [AW-1:0]  a_next, b_next, c_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < D; k++) begin
        pp[k] <= p[k] * p[k];
        pv[k] <= p[k] * v[k];
        vv[k] <= v[k] * v[k];
      end
      gg <= g * g;
      rg <= r * g;
      rr <= r * r;
      r1 <= r;
      n1 <= in_never;
      a         <= a_next;
      b         <= b_next;
      c         <= c_next;
      rtol      <= r1 >> TOL_SHIFT;
      out_never <= n1;
    end
  end

  always_comb begin
    a_next = -$signed({4'b0, gg});
    b_next = -$signed({4'b0, rg});
    c_next = -$signed({4'b0, rr});
    for (int k = 0; k < D; k++) begin
      a_next = a_next + {{4{vv[k][2*W-1]}}, vv[k]};
      b_next = b_next + {{4{pv[k][2*W-1]}}, pv[k]};
      c_next = c_next + {{4{pp[k][2*W-1]}}, pp[k]};
    end
  end

endmodule

>>> src/gsct_det.sv
// ----------------------------------------------------------------------------
// gsct_det
// Three register stages: split products, partial sums, discriminant and
// case selection.
// ----------------------------------------------------------------------------
module gsct_det
  import gsct_pkg::*;
#(
  parameter int W  = 32,
  parameter int AW = 2 * W + 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [AW-1:0]  a,
  input  logic signed [AW-1:0]  b,
  input  logic signed [AW-1:0]  c,
  input  logic        [W-1:0]   rtol,
  input  logic                  in_never,
  output logic                  out_valid,
  output logic        [2*AW-1:0] det,
  output logic signed [AW-1:0]  out_a,
  output logic signed [AW-1:0]  out_b,
  output logic signed [AW-1:0]  out_c,
  output res_kind_t             kind
);

  localparam int H = AW / 2;

  logic [AW-1:0] ma, mb, mc;
  logic [AW-1:0] bhh, bhl, bll, ahh, ahl, alh, all_p;
  logic          acneg3, acneg4;
  logic [2*AW-1:0] bb, ac;
  logic signed [AW-1:0] a3, b3, c3, a4, b4, c4;
  res_kind_t     k3, k4, kind_next, k3_next;
  logic          v3, v4;
  logic signed [AW:0] ovl;
  logic signed [2*AW:0] dsum;

  assign ma = a[AW-1] ? AW'(-a) : AW'(a);
  assign mb = b[AW-1] ? AW'(-b) : AW'(b);
  assign mc = c[AW-1] ? AW'(-c) : AW'(c);
  assign ovl = {c[AW-1], c} + $signed({{(AW+1-W){1'b0}}, rtol});

  always_comb begin
    if (in_never) begin
      k3_next = RES_NEVER;
    end else if (ovl[AW]) begin
      k3_next = RES_OVERLAP;
    end else if (c[AW-1] || c == '0) begin
      k3_next = b[AW-1] ? RES_ZERO : RES_NEVER;
    end else begin
      k3_next = RES_CALC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v3        <= in_valid;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bhh    <= mb[AW-1:H] * mb[AW-1:H];
      bhl    <= mb[AW-1:H] * mb[H-1:0];
      bll    <= mb[H-1:0] * mb[H-1:0];
      ahh    <= ma[AW-1:H] * mc[AW-1:H];
      ahl    <= ma[AW-1:H] * mc[H-1:0];
      alh    <= ma[H-1:0] * mc[AW-1:H];
      all_p  <= ma[H-1:0] * mc[H-1:0];
      acneg3 <= a[AW-1] ^ c[AW-1];
      a3 <= a;
      b3 <= b;
      c3 <= c;
      k3 <= k3_next;
      bb <= ({{AW{1'b0}}, bhh} << AW) + ({{AW{1'b0}}, bhl} << (H + 1))
          + {{AW{1'b0}}, bll};
      ac <= ({{AW{1'b0}}, ahh} << AW) + (({{AW{1'b0}}, ahl} + {{AW{1'b0}}, alh}) << H)
          + {{AW{1'b0}}, all_p};
      acneg4 <= acneg3;
      a4 <= a3;
      b4 <= b3;
      c4 <= c3;
      k4 <= k3;
      det   <= dsum[2*AW-1:0];
      out_a <= a4;
      out_b <= b4;
      out_c <= c4;
      kind  <= kind_next;
    end
  end

  assign dsum = acneg4 ? $signed({1'b0, bb}) + $signed({1'b0, ac})
                       : $signed({1'b0, bb}) - $signed({1'b0, ac});

  always_comb begin
    kind_next = k4;
    if (k4 == RES_CALC) begin
      if (dsum[2*AW]) begin
        kind_next = RES_NEVER;
      end else if (!b4[AW-1] && !(a4[AW-1] && b4 != '0)) begin
        kind_next = RES_NEVER;
      end
    end
  end

endmodule

>>> src/gsct_sqrt.sv
// ----------------------------------------------------------------------------
// gsct_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module gsct_sqrt #(
  parameter int RW = 68,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_det,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);

  logic            vld  [RW];
  logic [RW+1:0]   rem  [RW];
  logic [RW-1:0]   root [RW];
  logic [2*RW-1:0] dsh  [RW];
  logic [SW-1:0]   side [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            pv;
    logic [RW+1:0]   prem, rin, trial;
    logic [RW-1:0]   proot;
    logic [2*RW-1:0] pd;
    logic [SW-1:0]   pside;
    logic            ge;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign proot = '0;
      assign pd    = in_det;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld[k-1];
      assign prem  = rem[k-1];
      assign proot = root[k-1];
      assign pd    = dsh[k-1];
      assign pside = side[k-1];
    end

    assign rin   = {prem[RW-1:0], pd[2*RW-1:2*RW-2]};
    assign trial = {proot, 2'b01};
    assign ge    = rin >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? rin - trial : rin;
        root[k] <= {proot[RW-2:0], ge};
        dsh[k]  <= {pd[2*RW-3:0], 2'b00};
        side[k] <= pside;
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_root  = root[RW-1];
  assign out_side  = side[RW-1];

endmodule

>>> src/gsct_div.sv
// ----------------------------------------------------------------------------
// gsct_div
// Pipelined restoring divider with saturation, one quotient bit per stage.
// ----------------------------------------------------------------------------
module gsct_div #(
  parameter int NW  = 87,
  parameter int DNW = 69,
  parameter int QW  = 48,
  parameter int SW  = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  num,
  input  logic [DNW-1:0] den,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [QW-1:0]  quot,
  output logic [SW-1:0]  out_side
);

  logic [NW+QW-1:0] numx;
  logic [NW-1:0]    hi;

  logic           v0, ov0;
  logic [DNW:0]   rem0;
  logic [QW-1:0]  nl0;
  logic [DNW-1:0] den0;
  logic [SW-1:0]  side0;

  logic           vld  [QW];
  logic           ov   [QW];
  logic [DNW:0]   rem  [QW];
  logic [QW-1:0]  nl   [QW];
  logic [QW-1:0]  q    [QW];
  logic [DNW-1:0] dq   [QW];
  logic [SW-1:0]  side [QW];

  assign numx = {{QW{1'b0}}, num};
  assign hi   = numx[NW+QW-1:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ov0   <= hi >= {{(NW-DNW){1'b0}}, den};
      rem0  <= hi[DNW:0];
      nl0   <= numx[QW-1:0];
      den0  <= den;
      side0 <= in_side;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic           pv, pov;
    logic [DNW:0]   prem, r2;
    logic [QW-1:0]  pnl, pq;
    logic [DNW-1:0] pden;
    logic [SW-1:0]  pside;
    logic           ge;

    if (k == 0) begin : g_first
      assign pv    = v0;
      assign pov   = ov0;
      assign prem  = rem0;
      assign pnl   = nl0;
      assign pq    = '0;
      assign pden  = den0;
      assign pside = side0;
    end else begin : g_next
      assign pv    = vld[k-1];
      assign pov   = ov[k-1];
      assign prem  = rem[k-1];
      assign pnl   = nl[k-1];
      assign pq    = q[k-1];
      assign pden  = dq[k-1];
      assign pside = side[k-1];
    end

    assign r2 = {prem[DNW-1:0], pnl[QW-1]};
    assign ge = r2 >= {1'b0, pden};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ov[k]   <= pov;
        rem[k]  <= ge ? r2 - {1'b0, pden} : r2;
        nl[k]   <= {pnl[QW-2:0], 1'b0};
        q[k]    <= {pq[QW-2:0], ge};
        dq[k]   <= pden;
        side[k] <= pside;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quot      = ov[QW-1] ? '1 : q[QW-1];
  assign out_side  = side[QW-1];

endmodule

>>> src/growing_sphere_collision_time.sv
// Most of the pipeline depth lies in the one-bit-per-stage square root and divider
// pipelines.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits at the output and m_tready is low.
// Reset clears valid bits and hard_walls; data registers are not reset.
// ----------------------------------------------------------------------------
// growing_sphere_collision_time
// Contact time of two spheres with linearly growing radii, Q24.24 out.
// ----------------------------------------------------------------------------
module growing_sphere_collision_time
  import gsct_pkg::*;
#(
  parameter int DIMENSIONS  = 3,
  parameter int COORD_WIDTH = 32,
  parameter int TIME_WIDTH  = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z,
  // radius_sum, growth_sum (32 bits each)
  input  logic [255:0]                        s_tdata,
  // image_shifted
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // contact_time, zero padded to whole bytes
  output logic [((TIME_WIDTH+7)/8)*8-1:0]     m_tdata,
  // never_meets, overlap_error
  output logic [1:0]                          m_tuser
);

  localparam int W   = COORD_WIDTH;
  localparam int AW  = 2 * W + 4;
  localparam int NW  = AW + 1 + SCALE_SHIFT;
  localparam int DNW = AW + 1;
  localparam int OBW = ((TIME_WIDTH + 7) / 8) * 8;

  logic en;
  logic hard_walls;

  logic signed [W-1:0] p [3];
  logic signed [W-1:0] v [3];
  logic [W-1:0] r, g;

  logic                 q_valid, q_never;
  logic signed [AW-1:0] qa, qb, qc;
  logic [W-1:0]         qtol;

  logic                 d_valid;
  logic [2*AW-1:0]      det;
  logic signed [AW-1:0] da, db, dc;
  res_kind_t            dkind;

  logic                 s_valid;
  logic [AW-1:0]        root;
  logic [3*AW+1:0]      s_side;
  logic signed [AW-1:0] sa, sb, sc;
  res_kind_t            skind;

  logic                 n_valid;
  logic [NW-1:0]        num;
  logic [DNW-1:0]       den;
  res_kind_t            nkind;

  logic                 v_valid;
  logic [TIME_WIDTH-1:0] quot;
  logic [1:0]           vside;
  res_kind_t            vkind;

  logic [TIME_WIDTH-1:0] ctime;
  logic [1:0]            flags;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_HARD_WALLS) ? {31'b0, hard_walls} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hard_walls <= 1'b0;
    end else if (psel && penable && pwrite && paddr == ADDR_HARD_WALLS) begin
      hard_walls <= pwdata[0];
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p[k] = W'({{W{1'b0}}, s_tdata[32*k +: 32]});
      v[k] = W'({{W{1'b0}}, s_tdata[32*(k+3) +: 32]});
    end
    r = W'({{W{1'b0}}, s_tdata[223:192]});
    g = W'({{W{1'b0}}, s_tdata[255:224]});
  end

  gsct_quad #(.W(W), .D(DIMENSIONS), .AW(AW)) u_quad (
    .clk, .rst, .en,
    .in_valid  (s_tvalid && s_tready),
    .p, .v, .r, .g,
    .in_never  (hard_walls && s_tuser[0]),
    .out_valid (q_valid),
    .a (qa), .b (qb), .c (qc),
    .rtol      (qtol),
    .out_never (q_never)
  );

  gsct_det #(.W(W), .AW(AW)) u_det (
    .clk, .rst, .en,
    .in_valid  (q_valid),
    .a (qa), .b (qb), .c (qc),
    .rtol      (qtol),
    .in_never  (q_never),
    .out_valid (d_valid),
    .det,
    .out_a (da), .out_b (db), .out_c (dc),
    .kind  (dkind)
  );

  gsct_sqrt #(.RW(AW), .SW(3*AW+2)) u_sqrt (
    .clk, .rst, .en,
    .in_valid  (d_valid),
    .in_det    (det),
    .in_side   ({dkind, da, db, dc}),
    .out_valid (s_valid),
    .out_root  (root),
    .out_side  (s_side)
  );

  assign skind = res_kind_t'(s_side[3*AW+1:3*AW]);
  assign sa    = s_side[3*AW-1:2*AW];
  assign sb    = s_side[2*AW-1:AW];
  assign sc    = s_side[AW-1:0];

  // numerator and denominator of the stable root
  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else if (en) begin
      n_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nkind <= skind;
      if (sb[AW-1]) begin
        num <= {{(NW-AW){1'b0}}, sc} << SCALE_SHIFT;
        den <= {1'b0, root} - {sb[AW-1], sb};
      end else begin
        num <= ({{(NW-AW){1'b0}}, sb} + {{(NW-AW){1'b0}}, root}) << SCALE_SHIFT;
        den <= -{sa[AW-1], sa};
      end
    end
  end

  gsct_div #(.NW(NW), .DNW(DNW), .QW(TIME_WIDTH), .SW(2)) u_div (
    .clk, .rst, .en,
    .in_valid  (n_valid),
    .num, .den,
    .in_side   (nkind),
    .out_valid (v_valid),
    .quot,
    .out_side  (vside)
  );

  assign vkind = res_kind_t'(vside);

  always_comb begin
    case (vkind)
      RES_CALC: begin
        ctime = quot;
        flags = 2'b00;
      end
      RES_ZERO: begin
        ctime = '0;
        flags = 2'b00;
      end
      RES_OVERLAP: begin
        ctime = '0;
        flags = 2'b10;
      end
      default: begin
        ctime = '1;
        flags = 2'b01;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OBW'(ctime);
      m_tuser <= flags;
    end
  end

endmodule

>>> tb/sv/growing_sphere_collision_time_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// growing_sphere_collision_time_tb
// Drives sphere-pair requests through the contact-time pipeline and checks
// every result against a local integer predictor, across boundary modes and
// handshake idling phases, including a long output stall and a full drain.
// ----------------------------------------------------------------------------
module growing_sphere_collision_time_tb;
  import gsct_pkg::*;

  localparam int TW = 48;
  localparam logic [47:0] T_NEVER = {TW{1'b1}};
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [47:0] t;
    logic        never;
    logic        ovl;
  } contact_t;

  typedef struct {
    logic [31:0] px, py, pz, vx, vy, vz, rs, gs;
    logic        img;
  } pair_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 0, s_tready;
  logic [255:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid, m_tready = 0;
  logic [47:0] m_tdata;
  logic [1:0] m_tuser;

  growing_sphere_collision_time uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  logic walls_mode = 0;
  contact_t expected_contacts[$];
  int errors = 0, cycles = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_output = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic signed [255:0] sx(input logic [31:0] v);
    return {{224{v[31]}}, v};
  endfunction

  function automatic logic [255:0] isqrt(input logic [255:0] n);
    logic [255:0] r, c;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      c = r | (256'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic contact_t predict_contact(input pair_t p);
    logic signed [255:0] a, b, c, det, s, num, den, rs, gs;
    logic [255:0] q;
    contact_t r;
    r = '{t: T_NEVER, never: 1'b1, ovl: 1'b0};
    if (walls_mode && p.img) return r;
    rs = {224'd0, p.rs};
    gs = {224'd0, p.gs};
    a = sx(p.vx) * sx(p.vx) + sx(p.vy) * sx(p.vy) + sx(p.vz) * sx(p.vz) - gs * gs;
    b = sx(p.px) * sx(p.vx) + sx(p.py) * sx(p.vy) + sx(p.pz) * sx(p.vz) - rs * gs;
    c = sx(p.px) * sx(p.px) + sx(p.py) * sx(p.py) + sx(p.pz) * sx(p.pz) - rs * rs;
    if (c + (rs >>> TOL_SHIFT) < 0) return '{t: '0, never: 1'b0, ovl: 1'b1};
    if (c <= 0) begin
      if (b < 0) r = '{t: '0, never: 1'b0, ovl: 1'b0};
      return r;
    end
    det = b * b - a * c;
    if (det < 0) return r;
    s = isqrt(det);
    if (b < 0) begin
      num = c <<< SCALE_SHIFT;
      den = s - b;
    end else if (a < 0 && b != 0) begin
      num = (b + s) <<< SCALE_SHIFT;
      den = -a;
    end else begin
      return r;
    end
    q = $unsigned(num) / $unsigned(den);
    r.never = 1'b0;
    r.t = (q < {208'd0, T_NEVER}) ? q[47:0] : T_NEVER;
    return r;
  endfunction

  task automatic write_walls(input logic v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= ADDR_HARD_WALLS; pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    walls_mode = v;
  endtask

  task automatic send_pair(input pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {p.gs, p.rs, p.vz, p.vy, p.vx, p.pz, p.py, p.px};
    s_tuser <= p.img;
    expected_contacts.push_back(predict_contact(p));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("growing_sphere_collision_time_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) m_tready <= !hold_output && ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_contacts.size() == 0) begin
        report("unexpected", {m_tuser, m_tdata}, '0);
      end else begin
        contact_t e;
        e = expected_contacts.pop_front();
        if (m_tdata !== e.t) report("contact_time", m_tdata, e.t);
        if (m_tuser[0] !== e.never) report("never_meets", m_tuser[0], e.never);
        if (m_tuser[1] !== e.ovl) report("overlap_error", m_tuser[1], e.ovl);
      end
    end
  end

  // signed Q2.30 positions, Q8.24 velocities
  localparam logic [31:0] ONE_P = 32'h4000_0000, ONE_V = 32'h0100_0000;

  function automatic pair_t rand_pair();
    pair_t p;
    int m;
    m = $urandom_range(9);
    p.px = $urandom; p.py = $urandom; p.pz = $urandom;
    p.vx = $urandom; p.vy = $urandom; p.vz = $urandom;
    p.rs = $urandom; p.gs = $urandom; p.img = $urandom;
    if (m < 7) begin
      // moderate approaching pairs, to reach the root computation
      p.px = $signed($urandom_range(32'h3000_0000)) - 32'sh1800_0000;
      p.py = $signed($urandom_range(32'h3000_0000)) - 32'sh1800_0000;
      p.pz = $signed($urandom_range(32'h3000_0000)) - 32'sh1800_0000;
      p.vx = -($signed(p.px) >>> $urandom_range(12, 4)) + $signed($urandom_range(4095)) - 2048;
      p.vy = -($signed(p.py) >>> $urandom_range(12, 4));
      p.vz = -($signed(p.pz) >>> $urandom_range(12, 4));
      p.rs = $urandom_range(32'h1000_0000);
      p.gs = $urandom_range(m < 3 ? 32'h0400_0000 : 32'h0000_ffff);
    end else if (m == 7) begin
      p.rs = $urandom | 32'h8000_0000;
    end
    return p;
  endfunction

  typedef struct {
    pair_t p;
    bit    known;
    contact_t e;
  } row_t;

  row_t table_rows[$];

  function automatic pair_t mk(input logic [31:0] px, vx, rs, gs, input logic img);
    pair_t p;
    p = '{px: px, py: 0, pz: 0, vx: vx, vy: 0, vz: 0, rs: rs, gs: gs, img: img};
    return p;
  endfunction

  initial begin
    pair_t p;
    contact_t got;
    row_t r;
    repeat (5) @(posedge clk);
    rst <= 0;
    write_walls(0);

    // directed table
    table_rows.push_back('{mk(0, 0, 0, 0, 0), 1, '{T_NEVER, 1, 0}});
    table_rows.push_back('{mk(0, 0, ONE_P, 0, 0), 1, '{48'd0, 0, 1}});
    table_rows.push_back('{mk(ONE_P, -ONE_V, ONE_P, 0, 0), 1, '{48'd0, 0, 0}});
    table_rows.push_back('{mk(ONE_P, ONE_V, ONE_P, 0, 0), 1, '{T_NEVER, 1, 0}});
    table_rows.push_back('{mk(ONE_P, ONE_V, 0, 0, 0), 1, '{T_NEVER, 1, 0}});
    table_rows.push_back('{mk(32'h7fff_ffff, 32'h8000_0000, 0, 0, 1), 0, '{0, 0, 0}});
    table_rows.push_back('{mk(32'h8000_0000, 32'h7fff_ffff, 0, 0, 0), 0, '{0, 0, 0}});
    table_rows.push_back('{mk(32'h7fff_ffff, -32'd1, 0, 0, 0), 0, '{0, 0, 0}});
    table_rows.push_back('{mk(32'h7fff_ffff, 0, 0, 32'd1, 0), 0, '{0, 0, 0}});
    table_rows.push_back('{mk(32'h7fff_ffff, ONE_V, 0, 32'hffff_ffff, 0), 0, '{0, 0, 0}});
    table_rows.push_back('{mk(ONE_P, 32'h0100_0000, 0, 32'h0100_0000, 0), 0, '{0, 0, 0}});
    table_rows.push_back('{mk(ONE_P, 0, 0, ONE_V, 1), 0, '{0, 0, 0}});
    table_rows.push_back('{mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                              32'hffff_ffff, 1), 0, '{0, 0, 0}});
    p = '{px: ONE_P, py: ONE_P, pz: ONE_P, vx: -ONE_V, vy: ONE_V, vz: 0,
          rs: 32'h2000_0000, gs: 0, img: 0};
    table_rows.push_back('{p, 0, '{0, 0, 0}});
    p.vy = -ONE_V; p.vz = -ONE_V;
    table_rows.push_back('{p, 0, '{0, 0, 0}});
    // just inside contact, beyond the tolerance band
    table_rows.push_back('{mk(ONE_P - 1, 0, ONE_P, 0, 0), 0, '{0, 0, 0}});
    foreach (table_rows[i]) begin
      r = table_rows[i];
      got = predict_contact(r.p);
      if (r.known && got !== r.e) report("table row", got, r.e);
      send_pair(r.p);
    end
    drain();

    write_walls(1);
    send_pair(mk(ONE_P, -ONE_V, ONE_P, 0, 1));
    send_pair(mk(ONE_P, -ONE_V, ONE_P, 0, 0));

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_walls(ph[0]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (ph == 4) begin
        hold_output = 1;
        fork
          begin repeat (400) @(posedge clk); hold_output = 0; end
        join_none
      end
      repeat (85) send_pair(rand_pair());
    end
    drain();
    if (errors == 0)
      $display("growing_sphere_collision_time_tb: done, clean");
    else
      $display("growing_sphere_collision_time_tb: done, errors");
    $finish;
  end
endmodule
